// ----- hw/rtl/w2s_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// w2s_pkg
// Shared constants, types and the CORDIC arctangent table of the camera
// transform.
// ----------------------------------------------------------------------------
package w2s_pkg;

  localparam int SCREEN_WIDTH  = 800;
  localparam int SCREEN_HEIGHT = 600;

  // CORDIC: 21 iterations, angle units 2^24 per turn, Q30 start gain
  localparam int CORDIC_STEPS = 21;
  localparam int CW = 33;   // x/y datapath width (Q30 with growth)
  localparam int ZW = 25;   // residual angle width
  localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;

  // register indexes
  localparam logic [2:0] REG_OFS_X = 3'd0;
  localparam logic [2:0] REG_OFS_Y = 3'd1;
  localparam logic [2:0] REG_ZOOM  = 3'd2;
  localparam logic [2:0] REG_ROT   = 3'd3;
  localparam logic [2:0] REG_TILT  = 3'd4;

  // state handed from one CORDIC cell to the next, for both angles
  typedef struct packed {
    logic                 valid;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [ZW-1:0] pz;
    logic                 pflip;
    logic                 pexact;
    logic signed [17:0]   pc;
    logic signed [17:0]   ps;
    logic signed [CW-1:0] ty;
    logic signed [ZW-1:0] tz;
    logic                 tflip;
    logic                 texact;
    logic signed [17:0]   ts;
    logic signed [23:0]   wx;
    logic signed [23:0]   wy;
    logic signed [23:0]   hz;
    logic signed [CW-1:0] tx;
  } w2s_cell_t;

  function automatic logic signed [ZW-1:0] atan_step(input int i);
    logic signed [ZW-1:0] r;
    begin
      case (i)
        0:  r = 25'sd2097152;
        1:  r = 25'sd1238021;
        2:  r = 25'sd654136;
        3:  r = 25'sd332050;
        4:  r = 25'sd166669;
        5:  r = 25'sd83416;
        6:  r = 25'sd41718;
        7:  r = 25'sd20860;
        8:  r = 25'sd10430;
        9:  r = 25'sd5215;
        10: r = 25'sd2608;
        11: r = 25'sd1304;
        12: r = 25'sd652;
        13: r = 25'sd326;
        14: r = 25'sd163;
        15: r = 25'sd81;
        16: r = 25'sd41;
        17: r = 25'sd20;
        18: r = 25'sd10;
        19: r = 25'sd5;
        default: r = 25'sd3;
      endcase
      return r;
    end
  endfunction

endpackage

// ----- hw/rtl/w2s_cordic_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// w2s_cordic_cell
// One CORDIC rotation step for the plane angle and the tilt angle; the rest
// of the beat rides along to the next cell.
// ----------------------------------------------------------------------------
module w2s_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  w2s_pkg::w2s_cell_t  din,
  output w2s_pkg::w2s_cell_t  dout
);

  w2s_pkg::w2s_cell_t nxt;

  // rotate both vectors one step toward zero residual angle
  always_comb begin
    nxt = din;
    if (din.pz >= 0) begin
      nxt.px = din.px - (din.py >>> STEP);
      nxt.py = din.py + (din.px >>> STEP);
      nxt.pz = din.pz - w2s_pkg::atan_step(STEP);
    end else begin
      nxt.px = din.px + (din.py >>> STEP);
      nxt.py = din.py - (din.px >>> STEP);
      nxt.pz = din.pz + w2s_pkg::atan_step(STEP);
    end
    if (din.tz >= 0) begin
      nxt.tx = din.tx - (din.ty >>> STEP);
      nxt.ty = din.ty + (din.tx >>> STEP);
      nxt.tz = din.tz - w2s_pkg::atan_step(STEP);
    end else begin
      nxt.tx = din.tx + (din.ty >>> STEP);
      nxt.ty = din.ty - (din.tx >>> STEP);
      nxt.tz = din.tz + w2s_pkg::atan_step(STEP);
    end
  end

  // advance the beat when the chain moves
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
    if (en) begin
      dout.px <= nxt.px;  dout.py <= nxt.py;  dout.pz <= nxt.pz;
      dout.pflip <= nxt.pflip;  dout.pexact <= nxt.pexact;
      dout.pc <= nxt.pc;  dout.ps <= nxt.ps;
      dout.tx <= nxt.tx;  dout.ty <= nxt.ty;  dout.tz <= nxt.tz;
      dout.tflip <= nxt.tflip;  dout.texact <= nxt.texact;
      dout.ts <= nxt.ts;
      dout.wx <= nxt.wx;  dout.wy <= nxt.wy;  dout.hz <= nxt.hz;
    end
  end

endmodule

// ----- hw/rtl/w2s_math.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// w2s_math
// Offset, zoom, rotation, tilt and saturation, pipelined behind the CORDIC
// chain; one register after each multiply.
// ----------------------------------------------------------------------------
module w2s_math (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  w2s_pkg::w2s_cell_t  din,
  input  logic signed [23:0]  ofs_x,
  input  logic signed [23:0]  ofs_y,
  input  logic signed [15:0]  zoom,
  output logic                out_valid,
  output logic signed [15:0]  sx,
  output logic signed [15:0]  sy,
  output logic                clip
);

  localparam logic signed [25:0] CX = 26'(w2s_pkg::SCREEN_WIDTH * 128);
  localparam logic signed [25:0] CY = 26'(w2s_pkg::SCREEN_HEIGHT * 128);
  localparam logic signed [63:0] FY_C = 64'(w2s_pkg::SCREEN_HEIGHT) <<< 31;
  localparam logic signed [47:0] FX_C = 48'(w2s_pkg::SCREEN_WIDTH) <<< 15;

  // finish sine/cosine: round Q30 to Q16, fold back, quarter turns exact
  logic signed [w2s_pkg::CW-1:0] rxq, ryq, tyq;
  logic signed [17:0] cp, sp, st;
  always_comb begin
    rxq = (din.px + 33'sd8192) >>> 14;
    ryq = (din.py + 33'sd8192) >>> 14;
    tyq = (din.ty + 33'sd8192) >>> 14;
    if (din.pexact) begin
      cp = din.pc;
      sp = din.ps;
    end else begin
      cp = din.pflip ? -rxq[17:0] : rxq[17:0];
      sp = din.pflip ? -ryq[17:0] : ryq[17:0];
    end
    if (din.texact) st = din.ts;
    else st = din.tflip ? -tyq[17:0] : tyq[17:0];
  end

  // stage A: offset, centre, scale factor
  logic va;
  logic signed [25:0] ax, ay;
  logic signed [16:0] sc;
  logic signed [17:0] acp, asp, ast;
  logic signed [23:0] ahz;
  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else if (en) va <= din.valid;
    if (en) begin
      ax <= 26'(din.wx) + 26'(ofs_x) - CX;
      ay <= 26'(din.wy) + 26'(ofs_y) - CY;
      sc <= 17'sd256 + 17'(zoom);
      acp <= cp; asp <= sp; ast <= st; ahz <= din.hz;
    end
  end

  // stage B: zoom multiply
  logic vb;
  logic signed [42:0] dx, dy;
  logic signed [17:0] bcp, bsp, bst;
  logic signed [23:0] bhz;
  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else if (en) vb <= va;
    if (en) begin
      dx <= 43'(ax) * 43'(sc);
      dy <= 43'(ay) * 43'(sc);
      bcp <= acp; bsp <= asp; bst <= ast; bhz <= ahz;
    end
  end

  // stage C: four rotation products
  logic vc;
  logic signed [60:0] p_xc, p_ys, p_xs, p_yc;
  logic signed [17:0] cst;
  logic signed [23:0] chz;
  always_ff @(posedge clk) begin
    if (rst) vc <= 1'b0;
    else if (en) vc <= vb;
    if (en) begin
      p_xc <= 61'(dx) * 61'(bcp);
      p_ys <= 61'(dy) * 61'(bsp);
      p_xs <= 61'(dx) * 61'(bsp);
      p_yc <= 61'(dy) * 61'(bcp);
      cst <= bst; chz <= bhz;
    end
  end

  // stage D: sum and round rotation back to Q.16
  logic vd;
  logic signed [46:0] rx, ry;
  logic signed [17:0] dst;
  logic signed [23:0] dhz;
  logic signed [61:0] sum_x, sum_y;
  assign sum_x = 62'(p_xc) - 62'(p_ys) + 62'sd32768;
  assign sum_y = 62'(p_xs) + 62'(p_yc) + 62'sd32768;
  always_ff @(posedge clk) begin
    if (rst) vd <= 1'b0;
    else if (en) vd <= vc;
    if (en) begin
      rx <= 47'(sum_x >>> 16);
      ry <= 47'(sum_y >>> 16);
      dst <= cst; dhz <= chz;
    end
  end

  // stage E: tilt product
  logic ve;
  logic signed [47:0] fx;
  logic signed [46:0] ery;
  logic signed [66:0] tprod;
  logic signed [47:0] tt;
  assign tt = 48'(ry) - (48'(dhz) <<< 8);
  always_ff @(posedge clk) begin
    if (rst) ve <= 1'b0;
    else if (en) ve <= vd;
    if (en) begin
      tprod <= 67'(tt) * 67'(dst);
      ery <= ry;
      fx <= 48'(rx) + FX_C;
    end
  end

  // stage F: final y, truncate toward zero, saturate
  logic signed [67:0] fy;
  logic signed [47:0] ix, ixr;
  logic signed [67:0] iy, iyr;
  logic cx_hi, cx_lo, cy_hi, cy_lo;
  always_comb begin
    fy = (68'(ery) <<< 16) - 68'(tprod) + 68'(FY_C);
    ixr = fx >>> 16;
    ix = (fx < 0 && fx[15:0] != 16'd0) ? ixr + 48'sd1 : ixr;
    iyr = fy >>> 32;
    iy = (fy < 0 && fy[31:0] != 32'd0) ? iyr + 68'sd1 : iyr;
    cx_hi = ix > 48'sd32767;
    cx_lo = ix < -48'sd32768;
    cy_hi = iy > 68'sd32767;
    cy_lo = iy < -68'sd32768;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= ve;
    if (en) begin
      sx <= cx_hi ? 16'sd32767 : cx_lo ? -16'sd32768 : ix[15:0];
      sy <= cy_hi ? 16'sd32767 : cy_lo ? -16'sd32768 : iy[15:0];
      clip <= cx_hi | cx_lo | cy_hi | cy_lo;
    end
  end

endmodule

// ----- hw/rtl/world_to_screen_camera_transform.sv -----
`timescale 1ns / 1ps
// Pipeline: 1 entry stage, 21 CORDIC cells and 6 arithmetic stages between input
// beat and result beat; throughput one point per cycle while results are taken.
// The pipeline stalls as a whole when the result beat is not taken.
// Reset clears all valid flags and the configuration registers to zero.
// ----------------------------------------------------------------------------
// world_to_screen_camera_transform
// Maps world points to screen pixels: offset, zoom, rotate, tilt.
// ----------------------------------------------------------------------------
module world_to_screen_camera_transform (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid,
  output logic               ready,
  input  logic signed [23:0] world_x,
  input  logic signed [23:0] world_y,
  input  logic signed [23:0] height,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] screen_x,
  output logic signed [15:0] screen_y,
  output logic               clipped,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int N = w2s_pkg::CORDIC_STEPS;

  logic signed [23:0] ofs_x, ofs_y;
  logic signed [15:0] zoom;
  logic [15:0] rot, tilt;

  // register writes
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      ofs_x <= '0; ofs_y <= '0; zoom <= '0; rot <= '0; tilt <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        w2s_pkg::REG_OFS_X: ofs_x <= pwdata[23:0];
        w2s_pkg::REG_OFS_Y: ofs_y <= pwdata[23:0];
        w2s_pkg::REG_ZOOM:  zoom  <= pwdata[15:0];
        w2s_pkg::REG_ROT:   rot   <= pwdata[15:0];
        w2s_pkg::REG_TILT:  tilt  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (paddr[4:2])
      w2s_pkg::REG_OFS_X: prdata = {{8{ofs_x[23]}}, ofs_x};
      w2s_pkg::REG_OFS_Y: prdata = {{8{ofs_y[23]}}, ofs_y};
      w2s_pkg::REG_ZOOM:  prdata = {{16{zoom[15]}}, zoom};
      w2s_pkg::REG_ROT:   prdata = {16'd0, rot};
      w2s_pkg::REG_TILT:  prdata = {16'd0, tilt};
      default:            prdata = 32'd0;
    endcase
  end

  // whole pipeline advances unless the result beat is held
  logic en;
  assign en = !out_valid || out_ready;
  assign ready = en;

  // fold an angle into +-90 deg and seed the CORDIC
  function automatic w2s_pkg::w2s_cell_t seed_angle(input logic [15:0] a,
                                                    input logic is_tilt,
                                                    input w2s_pkg::w2s_cell_t s);
    w2s_pkg::w2s_cell_t r;
    logic signed [w2s_pkg::ZW-1:0] z;
    logic flip, exact;
    logic signed [17:0] c, sn;
    begin
      r = s;
      z = w2s_pkg::ZW'($signed({a, 8'd0}));
      flip = 1'b0;
      if (z > 25'sd4194304) begin
        z = z - 25'sd8388608; flip = 1'b1;
      end else if (z < -25'sd4194304) begin
        z = z + 25'sd8388608; flip = 1'b1;
      end
      exact = (a[13:0] == 14'd0);
      c = (a[15:14] == 2'd0) ? 18'sd65536 : (a[15:14] == 2'd2) ? -18'sd65536 : 18'sd0;
      sn = (a[15:14] == 2'd1) ? 18'sd65536 : (a[15:14] == 2'd3) ? -18'sd65536 : 18'sd0;
      if (is_tilt) begin
        r.tx = w2s_pkg::CORDIC_GAIN; r.ty = '0; r.tz = z;
        r.tflip = flip; r.texact = exact; r.ts = sn;
      end else begin
        r.px = w2s_pkg::CORDIC_GAIN; r.py = '0; r.pz = z;
        r.pflip = flip; r.pexact = exact; r.pc = c; r.ps = sn;
      end
      return r;
    end
  endfunction

  w2s_pkg::w2s_cell_t seed, chain [0:N];

  always_comb begin
    seed = '0;
    seed.valid = valid;
    seed.wx = world_x; seed.wy = world_y; seed.hz = height;
    seed = seed_angle(rot, 1'b0, seed);
    seed = seed_angle(tilt, 1'b1, seed);
  end

  // entry register
  always_ff @(posedge clk) begin
    if (rst) chain[0].valid <= 1'b0;
    else if (en) chain[0].valid <= seed.valid;
    if (en) begin
      chain[0].px <= seed.px; chain[0].py <= seed.py; chain[0].pz <= seed.pz;
      chain[0].pflip <= seed.pflip; chain[0].pexact <= seed.pexact;
      chain[0].pc <= seed.pc; chain[0].ps <= seed.ps;
      chain[0].tx <= seed.tx; chain[0].ty <= seed.ty; chain[0].tz <= seed.tz;
      chain[0].tflip <= seed.tflip; chain[0].texact <= seed.texact;
      chain[0].ts <= seed.ts;
      chain[0].wx <= seed.wx; chain[0].wy <= seed.wy; chain[0].hz <= seed.hz;
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    w2s_cordic_cell #(.STEP(g)) u_cell (
      .clk (clk), .rst (rst), .en (en),
      .din (chain[g]), .dout (chain[g+1])
    );
  end

  w2s_math u_math (
    .clk (clk), .rst (rst), .en (en), .din (chain[N]),
    .ofs_x (ofs_x), .ofs_y (ofs_y), .zoom (zoom),
    .out_valid (out_valid), .sx (screen_x), .sy (screen_y), .clip (clipped)
  );

endmodule
